@@ rtl/core/idtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_pkg
// Types, register indexes and helpers shared by the image diff compare core.
// ----------------------------------------------------------------------------
package idtc_pkg;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned MAX_CHANNELS = 4;

  localparam int unsigned POS_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned PIXC_W  = 25;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_TOLERANCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRACTION_Q16  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTUAL_CHANNELS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_CHANNELS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT      = 3'd5;

  localparam logic [7:0]  FAIL_RED    = 8'd255;
  localparam logic [7:0]  FAIL_OTHER  = 8'd0;
  localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);
  localparam logic [CHAN_W-1:0] CHAN_LIMIT   = CHAN_W'(MAX_CHANNELS);

  typedef struct packed {
    logic [7:0] actual_c0;
    logic [7:0] actual_c1;
    logic [7:0] actual_c2;
    logic [7:0] actual_c3;
    logic [7:0] expected_c0;
    logic [7:0] expected_c1;
    logic [7:0] expected_c2;
    logic [7:0] expected_c3;
  } in_t;

  typedef struct packed {
    logic [7:0]         diff_red;
    logic [7:0]         diff_green;
    logic [7:0]         diff_blue;
    logic               pixel_failed;
    logic               last_pixel;
    logic               status;
    logic [COUNT_W-1:0] failing_pixels;
    logic [7:0]         max_delta;
    logic [POS_W-1:0]   box_left;
    logic [ROW_W-1:0]   box_top;
    logic [POS_W-1:0]   box_right;
    logic [ROW_W-1:0]   box_bottom;
  } out_t;

  // Register values after range clamping, plus the cached pixel count.
  typedef struct packed {
    logic [7:0]        tolerance;
    logic [FRAC_W-1:0] fraction;
    logic [CHAN_W-1:0] actual_ch;
    logic [CHAN_W-1:0] compare_ch;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PIXC_W-1:0] frame_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] max_delta;
    logic       fail;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } eval_t;

  typedef struct packed {
    logic               last;
    logic [COUNT_W-1:0] failing_pixels;
    logic [7:0]         max_delta;
    logic [POS_W-1:0]   min_x;
    logic [ROW_W-1:0]   min_y;
    logic [POS_W-1:0]   max_x;
    logic [ROW_W-1:0]   max_y;
  } stats_t;

  typedef struct packed {
    eval_t  pix;
    stats_t stats;
  } mid_t;

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
    logic [CHAN_W-1:0] r;
    r = v;
    if (v == '0) r = CHAN_W'(1);
    else if (v > CHAN_LIMIT) r = CHAN_LIMIT;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/image_diff_tolerance_compare_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_diff_tolerance_compare_core
// Streaming image compare with per-channel tolerance and diff colour output.
//
// Requests on the input channel carry one actual and one expected pixel in
// raster order. Each request yields one result carrying the diff colour, the
// pixel's pass/fail flag and the running statistics; the result flagged as
// the last pixel also carries the image verdict in status.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while no request is in flight, as the core does not enforce it.
// out_valid rises once a request has passed the input, statistics and result
// registers. Throughput is one pixel per cycle while the receiver keeps
// out_ready high. The pipeline holds up to three requests, so a stalled
// receiver fills it and in_ready drops only when all stages are occupied.
// Reset clears the raster position and statistics and loads the register
// defaults (four channels, one by one image).
// ----------------------------------------------------------------------------
module image_diff_tolerance_compare_core
  import idtc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  in_t                         in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_t                        out_data
);

  cfg_t  cfg;
  in_t   s1_data;
  logic  s1_valid;
  logic  s1_fire;
  eval_t pix_res;
  stats_t snap;
  mid_t  s2_data;
  logic  s2_valid;
  logic  s2_ready;
  logic  take;

  idtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s2_ready = !s2_valid || take;
  assign s1_fire  = s1_valid && s2_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  idtc_pixel_eval u_eval (
    .pix (s1_data),
    .cfg (cfg),
    .res (pix_res)
  );

  idtc_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_fire),
    .cfg     (cfg),
    .pix     (pix_res),
    .snap    (snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_data.pix   <= pix_res;
      s2_data.stats <= snap;
    end
  end

  idtc_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .mid_valid    (s2_valid),
    .mid          (s2_data),
    .fraction     (cfg.fraction),
    .frame_pixels (cfg.frame_pixels),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/idtc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_cfg_regs
// Configuration register file with range clamping and a cached pixel count.
// ----------------------------------------------------------------------------
module idtc_cfg_regs
  import idtc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  logic [7:0]        tolerance;
  logic [FRAC_W-1:0] fraction;
  logic [CHAN_W-1:0] actual_ch;
  logic [CHAN_W-1:0] expected_ch;
  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;
  logic [PIXC_W-1:0] frame_pixels;

  logic [CHAN_W-1:0] act_cl;
  logic [CHAN_W-1:0] exp_cl;
  logic [SIZE_W-1:0] w_cl;
  logic [SIZE_W-1:0] h_cl;
  logic [2*SIZE_W-1:0] area;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= '0;
      fraction    <= '0;
      actual_ch   <= CHAN_W'(4);
      expected_ch <= CHAN_W'(4);
      width       <= SIZE_W'(1);
      height      <= SIZE_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHANNEL_TOLERANCE: tolerance   <= cfg_data[7:0];
        CFG_MAX_FRACTION_Q16:  fraction    <= cfg_data[FRAC_W-1:0];
        CFG_ACTUAL_CHANNELS:   actual_ch   <= cfg_data[CHAN_W-1:0];
        CFG_EXPECTED_CHANNELS: expected_ch <= cfg_data[CHAN_W-1:0];
        CFG_IMAGE_WIDTH:       width       <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT:      height      <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign act_cl = clamp_chan(actual_ch);
  assign exp_cl = clamp_chan(expected_ch);
  assign w_cl   = clamp_size(width, WIDTH_LIMIT);
  assign h_cl   = clamp_size(height, HEIGHT_LIMIT);
  assign area   = w_cl * h_cl;

  // The pixel count is registered from the clamped sizes; it is only read
  // by the final-pixel verdict, which sits two stages after acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= PIXC_W'(1);
    end else begin
      frame_pixels <= area[PIXC_W-1:0];
    end
  end

  always_comb begin
    cfg.tolerance    = tolerance;
    cfg.fraction     = fraction;
    cfg.actual_ch    = act_cl;
    cfg.compare_ch   = (act_cl < exp_cl) ? act_cl : exp_cl;
    cfg.width        = w_cl;
    cfg.height       = h_cl;
    cfg.frame_pixels = frame_pixels;
  end

endmodule
`default_nettype wire

@@ rtl/core/idtc_pixel_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_pixel_eval
// Per-pixel channel deltas, pass/fail decision and diff colour.
// ----------------------------------------------------------------------------
module idtc_pixel_eval
  import idtc_pkg::*;
(
  input  in_t  pix,
  input  cfg_t cfg,
  output eval_t res
);

  logic [7:0] a [4];
  logic [7:0] e [4];
  logic [7:0] d [4];
  logic [7:0] m01;
  logic [7:0] m23;
  logic [7:0] maxd;
  logic       fail;

  always_comb begin
    a[0] = pix.actual_c0;
    a[1] = pix.actual_c1;
    a[2] = pix.actual_c2;
    a[3] = pix.actual_c3;
    e[0] = pix.expected_c0;
    e[1] = pix.expected_c1;
    e[2] = pix.expected_c2;
    e[3] = pix.expected_c3;
    for (int c = 0; c < 4; c++) begin
      if (CHAN_W'(c) < cfg.compare_ch) begin
        d[c] = (a[c] > e[c]) ? (a[c] - e[c]) : (e[c] - a[c]);
      end else begin
        d[c] = '0;
      end
    end
    m01  = (d[0] > d[1]) ? d[0] : d[1];
    m23  = (d[2] > d[3]) ? d[2] : d[3];
    maxd = (m01 > m23) ? m01 : m23;
    fail = maxd > cfg.tolerance;
  end

  always_comb begin
    res.max_delta = maxd;
    res.fail      = fail;
    if (fail) begin
      res.red   = FAIL_RED;
      res.green = FAIL_OTHER;
      res.blue  = FAIL_OTHER;
    end else begin
      // Images with fewer channels fill green and blue from the grey channel.
      res.red   = a[0] >> 2;
      res.green = ((cfg.actual_ch > CHAN_W'(1)) ? a[1] : a[0]) >> 2;
      res.blue  = ((cfg.actual_ch > CHAN_W'(2)) ? a[2] : a[0]) >> 2;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/idtc_stats.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_stats
// Raster position, failing-pixel count, peak delta and bounding box.
// ----------------------------------------------------------------------------
module idtc_stats
  import idtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  cfg_t      cfg,
  input  eval_t     pix,
  output stats_t    snap
);

  logic [POS_W-1:0]   column_counter;
  logic [ROW_W-1:0]   row_counter;
  logic [COUNT_W-1:0] fail_count;
  logic [7:0]         peak_delta;
  logic [POS_W-1:0]   box_min_x;
  logic [ROW_W-1:0]   box_min_y;
  logic [POS_W-1:0]   box_max_x;
  logic [ROW_W-1:0]   box_max_y;
  logic               box_valid;

  logic [SIZE_W-1:0]  col_inc;
  logic [SIZE_W-1:0]  row_inc;
  logic               row_end;
  logic               last;
  stats_t             stats_next;

  always_comb begin
    col_inc = SIZE_W'(column_counter) + SIZE_W'(1);
    row_inc = SIZE_W'(row_counter) + SIZE_W'(1);
    row_end = col_inc >= cfg.width;
    last    = row_end && (row_inc >= cfg.height);

    stats_next.last           = last;
    stats_next.failing_pixels = fail_count;
    stats_next.max_delta      = (pix.max_delta > peak_delta) ? pix.max_delta : peak_delta;
    stats_next.min_x          = box_min_x;
    stats_next.min_y          = box_min_y;
    stats_next.max_x          = box_max_x;
    stats_next.max_y          = box_max_y;
    if (pix.fail) begin
      if (fail_count != '1) stats_next.failing_pixels = fail_count + COUNT_W'(1);
      if (!box_valid) begin
        stats_next.min_x = column_counter;
        stats_next.min_y = row_counter;
        stats_next.max_x = column_counter;
        stats_next.max_y = row_counter;
      end else begin
        if (column_counter < box_min_x) stats_next.min_x = column_counter;
        if (row_counter < box_min_y)    stats_next.min_y = row_counter;
        if (column_counter > box_max_x) stats_next.max_x = column_counter;
        if (row_counter > box_max_y)    stats_next.max_y = row_counter;
      end
    end
  end

  assign snap = stats_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      fail_count     <= '0;
      peak_delta     <= '0;
      box_min_x      <= '0;
      box_min_y      <= '0;
      box_max_x      <= '0;
      box_max_y      <= '0;
      box_valid      <= 1'b0;
    end else if (advance) begin
      if (last) begin
        // The final pixel of an image starts the next one from scratch.
        column_counter <= '0;
        row_counter    <= '0;
        fail_count     <= '0;
        peak_delta     <= '0;
        box_min_x      <= '0;
        box_min_y      <= '0;
        box_max_x      <= '0;
        box_max_y      <= '0;
        box_valid      <= 1'b0;
      end else begin
        if (row_end) begin
          column_counter <= '0;
          row_counter    <= row_inc[ROW_W-1:0];
        end else begin
          column_counter <= col_inc[POS_W-1:0];
        end
        fail_count <= stats_next.failing_pixels;
        peak_delta <= stats_next.max_delta;
        box_min_x  <= stats_next.min_x;
        box_min_y  <= stats_next.min_y;
        box_max_x  <= stats_next.max_x;
        box_max_y  <= stats_next.max_y;
        box_valid  <= box_valid || pix.fail;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/idtc_verdict.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_verdict
// Final-pixel fraction test and the result register.
// ----------------------------------------------------------------------------
module idtc_verdict
  import idtc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              mid_valid,
  input  mid_t                   mid,
  input  wire logic [FRAC_W-1:0] fraction,
  input  wire logic [PIXC_W-1:0] frame_pixels,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data
);

  localparam int unsigned CMP_W = FRAC_W + PIXC_W;

  logic [CMP_W-1:0] allowed;
  logic [CMP_W-1:0] scaled;
  logic             mismatch;

  // Failing count times 65536 against fraction times pixel count.
  assign allowed  = CMP_W'(fraction) * CMP_W'(frame_pixels);
  assign scaled   = CMP_W'({mid.stats.failing_pixels, 16'h0000});
  assign mismatch = mid.stats.last && (scaled > allowed);

  assign take = mid_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.diff_red       <= mid.pix.red;
      out_data.diff_green     <= mid.pix.green;
      out_data.diff_blue      <= mid.pix.blue;
      out_data.pixel_failed   <= mid.pix.fail;
      out_data.last_pixel     <= mid.stats.last;
      out_data.status         <= mismatch;
      out_data.failing_pixels <= mid.stats.failing_pixels;
      out_data.max_delta      <= mid.stats.max_delta;
      out_data.box_left       <= mid.stats.min_x;
      out_data.box_top        <= mid.stats.min_y;
      out_data.box_right      <= mid.stats.max_x;
      out_data.box_bottom     <= mid.stats.max_y;
    end
  end

endmodule
`default_nettype wire
